// File: src/dba_pkg.sv
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and constants for the decimal BCD accumulator.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int DIGITS_DEF = 64;
  localparam int OPD_BITS   = 31;
  localparam int OPD_DIGITS = 10;
  localparam int IDX_BITS   = 6;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_ADD     = 2'd1;
  localparam logic [1:0] KIND_MUL     = 2'd2;
  localparam logic [1:0] KIND_INSPECT = 2'd3;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [OPD_BITS-1:0] operand;
    logic [IDX_BITS-1:0] digit_index;
  } in_word_t;

  typedef struct packed {
    logic                was_greater;
    logic                was_equal;
    logic                was_less;
    logic [3:0]          digit_value;
    logic [IDX_BITS-1:0] top_index;
    logic                is_zero;
    logic                overflow;
  } out_word_t;

endpackage

// File: src/dba_bin2bcd.sv
// ----------------------------------------------------------------------------
// dba_bin2bcd
// Serial binary to BCD converter, one operand bit per cycle (shift-add-3).
// ----------------------------------------------------------------------------
module dba_bin2bcd (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [dba_pkg::OPD_BITS-1:0]         bin,
  output logic                                 done,
  output logic [4*dba_pkg::OPD_DIGITS-1:0]     bcd
);

  localparam int CW = $clog2(dba_pkg::OPD_BITS);
  localparam int BW = 4 * dba_pkg::OPD_DIGITS;

  logic                         busy_r;
  logic                         done_r;
  logic [CW-1:0]                cnt_r;
  logic [dba_pkg::OPD_BITS-1:0] bin_r;
  logic [BW-1:0]                bcd_r;
  logic [BW-1:0]                adj;

  always_comb begin
    for (int i = 0; i < dba_pkg::OPD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(dba_pkg::OPD_BITS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(dba_pkg::OPD_BITS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[dba_pkg::OPD_BITS-2:0], 1'b0};
      bcd_r <= {adj[BW-2:0], bin_r[dba_pkg::OPD_BITS-1]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// File: src/decimal_bcd_accumulator.sv
// ----------------------------------------------------------------------------
// decimal_bcd_accumulator
// Decimal accumulator over DIGITS BCD digits with load, add, multiply and
// inspect, plus a numeric compare of the prior value against the operand.
// ----------------------------------------------------------------------------
// One word at a time. After reset a clearing pass zeroes the digit memory,
// in_ready stays low meanwhile. Each word first converts its operand to ten
// BCD digits (one operand bit per cycle), then walks the digit memory from
// the ones digit upward through its single read/write port: load, add and
// inspect pass each digit through a read state and an execute state; multiply
// forms each result digit as a column of ten digit products on one shared 4x4
// multiplier, in read, shift, multiply-accumulate and execute states, over
// DIGITS+10 columns. A new word is taken while the previous result still
// waits on the output.
module decimal_bcd_accumulator #(
  parameter int DIGITS = dba_pkg::DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dba_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dba_pkg::out_word_t out_data
);

  localparam int ND = dba_pkg::OPD_DIGITS;
  localparam int AW = $clog2(DIGITS);
  localparam int KW = $clog2(DIGITS + ND + 1);
  localparam int TW = (KW > dba_pkg::IDX_BITS) ? KW : dba_pkg::IDX_BITS;
  localparam int JW = $clog2(ND);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CONV = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_SHF  = 3'd4;
  localparam logic [2:0] S_MAC  = 3'd5;
  localparam logic [2:0] S_EX   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] k_r;
  logic [JW-1:0] j_r;
  logic [1:0]    kind_r;
  logic [dba_pkg::IDX_BITS-1:0] idx_r;
  logic [1:0]    cmp_r;
  logic [6:0]    carry_r;
  logic [9:0]    acc_r;
  logic          nz_r;
  logic [dba_pkg::IDX_BITS-1:0] top_r;
  logic [3:0]    dig_r;
  logic          ovf_r;
  logic [3:0]    win_r [ND];
  logic          out_valid_r;
  dba_pkg::out_word_t out_data_r;

  logic [3:0]    mem [DIGITS];
  logic [3:0]    rdata_r;
  logic          mem_we;
  logic [3:0]    mem_wdata;

  logic          conv_start;
  logic          conv_done;
  logic [4*ND-1:0] conv_bcd;
  logic [3:0]    od [ND];

  logic          accept;
  logic          in_rng;
  logic [3:0]    a_dig, b_dig, new_dig;
  logic [4:0]    add_s;
  logic [9:0]    mul_p;
  logic [17:0]   mul_prod;
  logic [6:0]    mul_q;
  logic [3:0]    mul_rem;
  logic [6:0]    cout;
  logic          last_col;
  logic [TW-1:0] k_ext;

  dba_bin2bcd u_b2d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (in_data.operand),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      od[i] = conv_bcd[4*i +: 4];
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign conv_start = accept;

  assign in_rng = (k_r < KW'(DIGITS));
  assign k_ext  = TW'(k_r);
  assign a_dig  = in_rng ? rdata_r : 4'd0;
  assign b_dig  = (k_r < KW'(ND)) ? od[k_r[JW-1:0]] : 4'd0;
  assign add_s  = 5'(a_dig) + 5'(b_dig) + 5'(carry_r[0]);
  assign mul_p  = acc_r + 10'(carry_r);
  assign mul_prod = 18'(mul_p) * 18'd205;
  assign mul_q  = mul_prod[17:11];
  assign mul_rem = 4'(mul_p - 10'(mul_q) * 10'd10);

  always_comb begin
    unique case (kind_r)
      dba_pkg::KIND_LOAD: begin
        new_dig = b_dig;
        cout    = 7'd0;
      end
      dba_pkg::KIND_ADD: begin
        if (add_s >= 5'd10) begin
          new_dig = 4'(add_s - 5'd10);
          cout    = 7'd1;
        end else begin
          new_dig = add_s[3:0];
          cout    = 7'd0;
        end
      end
      dba_pkg::KIND_MUL: begin
        new_dig = mul_rem;
        cout    = mul_q;
      end
      default: begin
        new_dig = a_dig;
        cout    = 7'd0;
      end
    endcase
  end

  assign last_col = (kind_r == dba_pkg::KIND_MUL) ? (k_r == KW'(DIGITS + ND - 1))
                                                  : (k_r == KW'(DIGITS - 1));

  assign mem_we = (state_r == S_CLR) ||
                  ((state_r == S_EX) && in_rng && (kind_r != dba_pkg::KIND_INSPECT));
  assign mem_wdata = (state_r == S_CLR) ? 4'd0 : new_dig;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[k_r[AW-1:0]] <= mem_wdata;
    end
    if (state_r == S_RD) begin
      rdata_r <= mem[k_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (k_r == KW'(DIGITS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (accept) state_nxt = S_CONV;
      S_CONV: if (conv_done) state_nxt = S_RD;
      S_RD:   state_nxt = (kind_r == dba_pkg::KIND_MUL) ? S_SHF : S_EX;
      S_SHF:  state_nxt = S_MAC;
      S_MAC:  if (j_r == JW'(ND - 1)) state_nxt = S_EX;
      S_EX:   state_nxt = last_col ? S_DONE : S_RD;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        k_r <= (k_r == KW'(DIGITS - 1)) ? '0 : k_r + 1'b1;
      end else if (accept) begin
        k_r <= '0;
      end else if (state_r == S_EX && !last_col) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_data.kind;
      idx_r   <= in_data.digit_index;
      cmp_r   <= dba_pkg::CMP_EQ;
      carry_r <= 7'd0;
      nz_r    <= 1'b0;
      top_r   <= '0;
      dig_r   <= 4'd0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < ND; i++) begin
        win_r[i] <= 4'd0;
      end
    end
    if (state_r == S_SHF) begin
      win_r[0] <= a_dig;
      for (int i = 1; i < ND; i++) begin
        win_r[i] <= win_r[i-1];
      end
      acc_r <= 10'd0;
      j_r   <= '0;
    end
    if (state_r == S_MAC) begin
      acc_r <= acc_r + {2'b00, 8'(win_r[j_r] * od[j_r])};
      j_r   <= j_r + 1'b1;
    end
    if (state_r == S_EX) begin
      carry_r <= cout;
      if (in_rng) begin
        if (a_dig > b_dig) begin
          cmp_r <= dba_pkg::CMP_GT;
        end else if (a_dig < b_dig) begin
          cmp_r <= dba_pkg::CMP_LT;
        end
        if (new_dig != 4'd0) begin
          nz_r  <= 1'b1;
          top_r <= (k_ext > TW'(63)) ? 6'd63 : k_ext[dba_pkg::IDX_BITS-1:0];
        end
        if (TW'(idx_r) == k_ext) begin
          dig_r <= new_dig;
        end
      end
      if (kind_r == dba_pkg::KIND_ADD && last_col && cout != 7'd0) begin
        ovf_r <= 1'b1;
      end
      if (kind_r == dba_pkg::KIND_MUL &&
          ((!in_rng && new_dig != 4'd0) || (last_col && cout != 7'd0))) begin
        ovf_r <= 1'b1;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_data_r.was_greater <= (cmp_r == dba_pkg::CMP_GT);
      out_data_r.was_equal   <= (cmp_r == dba_pkg::CMP_EQ);
      out_data_r.was_less    <= (cmp_r == dba_pkg::CMP_LT);
      out_data_r.digit_value <= dig_r;
      out_data_r.top_index   <= top_r;
      out_data_r.is_zero     <= !nz_r;
      out_data_r.overflow    <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_data_r.was_greater, out_data_r.was_equal,
                             out_data_r.was_less}))
    else $error("compare flags not one-hot");

  a_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_zero |-> out_data_r.top_index == '0)
    else $error("zero value with nonzero top index");

  a_digit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.digit_value <= 4'd9)
    else $error("reported digit not decimal");

  a_mul_carry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EX && kind_r == dba_pkg::KIND_MUL |-> carry_r <= 7'd90)
    else $error("multiply column carry out of range");

endmodule
